// File: rtl/core/dmx_pkg.sv
// Shared constants and types for the DMX512 frame transmitter.
// No dependencies; dmx_if.sv and the top module in rtl/core import this package.
`default_nettype none

package dmx_pkg;

	// slot store geometry, start code included
	localparam int SLOTS   = 513;
	localparam int SLOT_AW = $clog2(SLOTS);

	// field widths
	localparam int OP_W   = 3;
	localparam int ADDR_W = 10;
	localparam int VAL_W  = 8;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [ADDR_W-1:0] SLOT_NUM = ADDR_W'(SLOTS);
	localparam logic [ADDR_W-1:0] SLOT_TOP = ADDR_W'(SLOTS - 1);

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_FILL   = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_RGB = 3'd2;
	localparam logic [OP_W-1:0] OP_RD_ONE = 3'd3;
	localparam logic [OP_W-1:0] OP_RD_RGB = 3'd4;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_FRAME_PERIOD = 3'd0;
	localparam logic [CFG_IW-1:0] REG_BREAK_TICKS  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_MAB_TICKS    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_HOLD_TICKS   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SLOT_COUNT   = 3'd4;

	// register reset values
	localparam logic [15:0] FRAME_PERIOD_RST = 16'd10000;
	localparam logic [7:0]  BREAK_TICKS_RST  = 8'd22;
	localparam logic [7:0]  MAB_TICKS_RST    = 8'd2;
	localparam logic [7:0]  HOLD_TICKS_RST   = 8'd11;
	localparam logic [9:0]  SLOT_COUNT_RST   = 10'd513;

	// start bit, 8 data bits, 2 stop bits
	localparam logic [3:0] BITS_PER_SLOT = 4'd11;
	localparam logic [3:0] LAST_DATA_BIT = 4'd8;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_BREAK = 5'b00010,
		PH_MAB   = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_HOLD  = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

// File: rtl/core/dmx_if.sv
// Channel interfaces of the DMX512 transmitter: operation request,
// response and configuration write. Depends on dmx_pkg.
`default_nettype none

interface dmx_req_if;
	import dmx_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] addr_first;
	logic [ADDR_W-1:0] addr_last;
	logic [VAL_W-1:0]  value_a;
	logic [VAL_W-1:0]  value_b;
	logic [VAL_W-1:0]  value_c;

	modport source(output valid, op, addr_first, addr_last, value_a, value_b, value_c,
		input ready);
	modport sink(input valid, op, addr_first, addr_last, value_a, value_b, value_c,
		output ready);
endinterface

interface dmx_rsp_if;
	import dmx_pkg::*;
	logic              valid;
	logic              ready;
	logic              line_level;
	logic              driver_enable;
	logic              frame_done;
	logic [ADDR_W-1:0] read_addr;
	logic [VAL_W-1:0]  read_a;
	logic [VAL_W-1:0]  read_b;
	logic [VAL_W-1:0]  read_c;
	logic              status;

	modport source(output valid, line_level, driver_enable, frame_done, read_addr,
		read_a, read_b, read_c, status, input ready);
	modport sink(input valid, line_level, driver_enable, frame_done, read_addr,
		read_a, read_b, read_c, status, output ready);
endinterface

interface dmx_cfg_if;
	import dmx_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dmx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/dmx512_frame_transmitter_top.sv
// DMX512 frame transmitter: slot store RAM, frame sequencer, operation engine.
// Depends on dmx_pkg, dmx_if.sv (interfaces) and dmx_ram.
//
// Usage:
//   req  carries one operation per transaction: a 4 us bit tick, a range fill,
//        an RGB write, a single read or an RGB read. Each yields one response.
//   rsp  returns line level, driver enable and frame_done for ticks, and the
//        echoed address, read data and status for slot operations.
//   cfg  writes frame_period, break_ticks, mab_ticks, hold_ticks, slot_count;
//        always ready, write only while no operation is outstanding.
// Flow: an operation is taken only by the idle engine, and its result is passed
// on through the response register; a fill writes its range one slot per cycle
// through the one RAM write port.
// The next request is taken while a response still waits in the output register.
// Reset: the slot store is cleared by a sweep over all SLOTS slots (513), one slot
// per cycle; req.ready stays low during the sweep, cfg writes are taken.
// Stall: with rsp.ready low the engine finishes the current operation and
// holds its result until the output register drains; later requests wait.
`default_nettype none

module dmx512_frame_transmitter_top (
	input wire logic   clk,
	input wire logic   arst_n,
	dmx_cfg_if.sink    cfg,
	dmx_req_if.sink    req,
	dmx_rsp_if.source  rsp
);
	import dmx_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b00000001,
		ST_IDLE  = 8'b00000010,
		ST_TICK  = 8'b00000100,
		ST_FILL  = 8'b00001000,
		ST_WR    = 8'b00010000,
		ST_RD    = 8'b00100000,
		ST_RDW   = 8'b01000000,
		ST_PUSH  = 8'b10000000
	} eng_state_t;

	eng_state_t state_q;

	// configuration
	logic [15:0] period_cfg_q;
	logic [7:0]  break_cfg_q;
	logic [7:0]  mab_cfg_q;
	logic [7:0]  hold_cfg_q;
	logic [9:0]  slots_cfg_q;

	// frame sequencer
	logic [15:0] period_q;
	phase_t      phase_q;
	logic [7:0]  pcnt_q;
	logic [9:0]  slot_q;
	logic [3:0]  bit_q;

	// operation engine
	logic [SLOT_AW-1:0] clr_q;
	logic [SLOT_AW-1:0] fill_q;
	logic [SLOT_AW-1:0] a0_q;
	logic [SLOT_AW-1:0] a1_q;
	logic [VAL_W-1:0]   va_q, vb_q, vc_q;
	logic [1:0]         k_q;
	logic [1:0]         rd_last_q;
	logic               rd_pend_s1;
	logic [1:0]         rd_idx_s1;

	// pending result
	logic              res_line_q, res_de_q, res_done_q, res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [VAL_W-1:0]  res_a_q, res_b_q, res_c_q;

	// output register
	logic              out_vld_q;
	logic              out_line_q, out_de_q, out_done_q, out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [VAL_W-1:0]  out_a_q, out_b_q, out_c_q;

	// RAM port
	logic               ram_we;
	logic [SLOT_AW-1:0] ram_waddr, ram_raddr;
	logic [VAL_W-1:0]   ram_wdata, ram_rdata;

	dmx_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);

	assign rsp.valid         = out_vld_q;
	assign rsp.line_level    = out_line_q;
	assign rsp.driver_enable = out_de_q;
	assign rsp.frame_done    = out_done_q;
	assign rsp.read_addr     = out_addr_q;
	assign rsp.read_a        = out_a_q;
	assign rsp.read_b        = out_b_q;
	assign rsp.read_c        = out_c_q;
	assign rsp.status        = out_status_q;

	// address range checks on the incoming request
	logic [ADDR_W:0] a0_plus2;
	logic            bad_one, bad_fill, bad_rgb;

	assign a0_plus2 = {1'b0, req.addr_first} + (ADDR_W+1)'(2);
	assign bad_one  = (req.addr_first > SLOT_TOP);
	assign bad_fill = bad_one || (req.addr_last > SLOT_TOP);
	assign bad_rgb  = (a0_plus2 > {1'b0, SLOT_TOP});

	// RAM access per engine state; idle keeps the current slot on the read port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = slot_q[SLOT_AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_q;
				ram_wdata = va_q;
			end
			ST_WR: begin
				ram_we    = 1'b1;
				ram_waddr = SLOT_AW'(a0_q + SLOT_AW'(k_q));
				ram_wdata = (k_q == 2'd0) ? va_q : ((k_q == 2'd1) ? vb_q : vc_q);
			end
			ST_RD: begin
				ram_raddr = SLOT_AW'(a0_q + SLOT_AW'(k_q));
			end
			default: begin
			end
		endcase
	end

	// one bit tick of the frame sequencer; ram_rdata holds slot slot_q
	logic [9:0]  spf;
	logic [16:0] pc1;
	logic [15:0] tk_period;
	phase_t      ph, tk_phase;
	logic [7:0]  pc, pinc, tk_pcnt;
	logic [9:0]  sinc, tk_slot;
	logic [3:0]  binc, tk_bit;
	logic [2:0]  bsel;
	logic        tk_level, tk_de, tk_done;

	always_comb begin
		if (slots_cfg_q == 10'd0) begin
			spf = 10'd1;
		end else if (slots_cfg_q > SLOT_NUM) begin
			spf = SLOT_NUM;
		end else begin
			spf = slots_cfg_q;
		end
	end

	always_comb begin
		pc1       = {1'b0, period_q} + 17'd1;
		tk_period = (pc1 >= {1'b0, period_cfg_q}) ? 16'd0 : pc1[15:0];
		ph        = phase_q;
		pc        = pcnt_q;
		if (phase_q == PH_IDLE && period_q == 16'd0) begin
			ph = PH_BREAK;
			pc = 8'd0;
		end
		pinc     = pc + 8'd1;
		binc     = bit_q + 4'd1;
		sinc     = slot_q + 10'd1;
		bsel     = 3'(bit_q - 4'd1);
		tk_phase = ph;
		tk_pcnt  = pc;
		tk_slot  = slot_q;
		tk_bit   = bit_q;
		tk_level = 1'b1;
		tk_de    = 1'b1;
		tk_done  = 1'b0;
		case (ph)
			PH_BREAK: begin
				tk_level = 1'b0;
				tk_pcnt  = pinc;
				if (pinc >= break_cfg_q) begin
					tk_phase = PH_MAB;
					tk_pcnt  = 8'd0;
				end
			end
			PH_MAB: begin
				tk_pcnt = pinc;
				if (pinc >= mab_cfg_q) begin
					tk_phase = PH_DATA;
					tk_pcnt  = 8'd0;
					tk_slot  = 10'd0;
					tk_bit   = 4'd0;
				end
			end
			PH_DATA: begin
				if (bit_q == 4'd0) begin
					tk_level = 1'b0;
				end else if (bit_q <= LAST_DATA_BIT) begin
					tk_level = ram_rdata[bsel];
				end
				tk_bit = binc;
				if (binc >= BITS_PER_SLOT) begin
					tk_bit  = 4'd0;
					tk_slot = sinc;
					if (sinc >= spf) begin
						tk_slot = 10'd0;
						tk_pcnt = 8'd0;
						if (hold_cfg_q == 8'd0) begin
							tk_phase = PH_IDLE;
							tk_done  = 1'b1;
						end else begin
							tk_phase = PH_HOLD;
						end
					end
				end
			end
			PH_HOLD: begin
				tk_pcnt = pinc;
				if (pinc >= hold_cfg_q) begin
					tk_phase = PH_IDLE;
					tk_pcnt  = 8'd0;
					tk_done  = 1'b1;
				end
			end
			default: begin
				tk_phase = PH_IDLE;
				tk_de    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			period_cfg_q <= FRAME_PERIOD_RST;
			break_cfg_q  <= BREAK_TICKS_RST;
			mab_cfg_q    <= MAB_TICKS_RST;
			hold_cfg_q   <= HOLD_TICKS_RST;
			slots_cfg_q  <= SLOT_COUNT_RST;
			period_q     <= '0;
			phase_q      <= PH_IDLE;
			pcnt_q       <= '0;
			slot_q       <= '0;
			bit_q        <= '0;
			clr_q        <= '0;
			fill_q       <= '0;
			a0_q         <= '0;
			a1_q         <= '0;
			va_q         <= '0;
			vb_q         <= '0;
			vc_q         <= '0;
			k_q          <= '0;
			rd_last_q    <= '0;
			rd_pend_s1   <= 1'b0;
			rd_idx_s1    <= '0;
			res_line_q   <= 1'b0;
			res_de_q     <= 1'b0;
			res_done_q   <= 1'b0;
			res_status_q <= 1'b0;
			res_addr_q   <= '0;
			res_a_q      <= '0;
			res_b_q      <= '0;
			res_c_q      <= '0;
			out_vld_q    <= 1'b0;
			out_line_q   <= 1'b0;
			out_de_q     <= 1'b0;
			out_done_q   <= 1'b0;
			out_status_q <= 1'b0;
			out_addr_q   <= '0;
			out_a_q      <= '0;
			out_b_q      <= '0;
			out_c_q      <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_FRAME_PERIOD: period_cfg_q <= cfg.data;
					REG_BREAK_TICKS:  break_cfg_q  <= cfg.data[7:0];
					REG_MAB_TICKS:    mab_cfg_q    <= cfg.data[7:0];
					REG_HOLD_TICKS:   hold_cfg_q   <= cfg.data[7:0];
					REG_SLOT_COUNT:   slots_cfg_q  <= cfg.data[9:0];
					default: begin
					end
				endcase
			end

			// read data lands in the cycle after the address was issued
			rd_pend_s1 <= 1'b0;
			if (rd_pend_s1) begin
				case (rd_idx_s1)
					2'd0:    res_a_q <= ram_rdata;
					2'd1:    res_b_q <= ram_rdata;
					default: res_c_q <= ram_rdata;
				endcase
			end

			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= SLOT_AW'(clr_q + 1'b1);
					if (clr_q == SLOT_AW'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						a0_q         <= req.addr_first[SLOT_AW-1:0];
						a1_q         <= req.addr_last[SLOT_AW-1:0];
						va_q         <= req.value_a;
						vb_q         <= req.value_b;
						vc_q         <= req.value_c;
						k_q          <= 2'd0;
						res_line_q   <= 1'b1;
						res_de_q     <= (phase_q != PH_IDLE);
						res_done_q   <= 1'b0;
						res_status_q <= 1'b0;
						res_addr_q   <= req.addr_first;
						res_a_q      <= '0;
						res_b_q      <= '0;
						res_c_q      <= '0;
						state_q      <= ST_PUSH;
						case (req.op)
							OP_TICK: begin
								res_addr_q <= '0;
								state_q    <= ST_TICK;
							end
							OP_FILL: begin
								if (bad_fill) begin
									res_status_q <= 1'b1;
								end else if (req.addr_first <= req.addr_last) begin
									fill_q  <= req.addr_first[SLOT_AW-1:0];
									state_q <= ST_FILL;
								end
							end
							OP_WR_RGB: begin
								if (bad_rgb) begin
									res_status_q <= 1'b1;
								end else begin
									state_q <= ST_WR;
								end
							end
							OP_RD_ONE: begin
								if (bad_one) begin
									res_status_q <= 1'b1;
								end else begin
									rd_last_q <= 2'd0;
									state_q   <= ST_RD;
								end
							end
							OP_RD_RGB: begin
								if (bad_rgb) begin
									res_status_q <= 1'b1;
								end else begin
									rd_last_q <= 2'd2;
									state_q   <= ST_RD;
								end
							end
							default: begin
								res_addr_q <= '0;
							end
						endcase
					end
				end
				ST_TICK: begin
					period_q   <= tk_period;
					phase_q    <= tk_phase;
					pcnt_q     <= tk_pcnt;
					slot_q     <= tk_slot;
					bit_q      <= tk_bit;
					res_line_q <= tk_level;
					res_de_q   <= tk_de;
					res_done_q <= tk_done;
					state_q    <= ST_PUSH;
				end
				ST_FILL: begin
					fill_q <= SLOT_AW'(fill_q + 1'b1);
					if (fill_q == a1_q) begin
						state_q <= ST_PUSH;
					end
				end
				ST_WR: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						state_q <= ST_PUSH;
					end
				end
				ST_RD: begin
					rd_pend_s1 <= 1'b1;
					rd_idx_s1  <= k_q;
					k_q        <= k_q + 2'd1;
					if (k_q == rd_last_q) begin
						state_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q    <= 1'b1;
						out_line_q   <= res_line_q;
						out_de_q     <= res_de_q;
						out_done_q   <= res_done_q;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						out_a_q      <= res_a_q;
						out_b_q      <= res_b_q;
						out_c_q      <= res_c_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// an accepted request leaves req.ready low in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while engine still busy");

	// a fill never writes past its last slot
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (fill_q <= a1_q))
		else $error("fill pointer ran past range end");

	// the data phase only addresses stored slots and valid bit positions
	a_data_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (slot_q < SLOT_NUM && bit_q < BITS_PER_SLOT))
		else $error("slot or bit index out of range in data phase");

	// a pushed result shows up on the response channel
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && (!out_vld_q || rsp.ready)) |=> rsp.valid)
		else $error("result lost between engine and output register");

endmodule

`default_nettype wire
